// ----- sv/cprn_pkg.sv -----
// Shared types, constants and rounding helper for the complex product RMS normalizer.
package cprn_pkg;

    localparam int CFG_W    = 7;
    localparam int IN_W     = 16;
    localparam int Z_W      = 32;
    localparam int ACC_W    = 64;
    localparam int SH_W     = 6;
    localparam int MUL_W    = 33;

    // Output scaling starts from 50 fraction bits before normalization.
    localparam logic [SH_W-1:0] SH_BASE = 6'd50;
    // The divider works on 2^61, so the walk goes from bit 61 down to bit 0.
    localparam logic [5:0] DIV_TOP = 6'd61;

    typedef enum logic [17:0] {
        ST_IDLE     = 18'b000000000000000001,
        ST_M_RR     = 18'b000000000000000010,
        ST_M_II     = 18'b000000000000000100,
        ST_M_RI     = 18'b000000000000001000,
        ST_M_IR     = 18'b000000000000010000,
        ST_SQ_R     = 18'b000000000000100000,
        ST_SQ_I     = 18'b000000000001000000,
        ST_SUM      = 18'b000000000010000000,
        ST_ACC      = 18'b000000000100000000,
        ST_NORM     = 18'b000000001000000000,
        ST_SQRT     = 18'b000000010000000000,
        ST_DIV      = 18'b000000100000000000,
        ST_MANT     = 18'b000001000000000000,
        ST_MANT2    = 18'b000010000000000000,
        ST_EMIT_RD  = 18'b000100000000000000,
        ST_EMIT_MR  = 18'b001000000000000000,
        ST_EMIT_MI  = 18'b010000000000000000,
        ST_EMIT_OUT = 18'b100000000000000000
    } cprn_state_t;

    // Round half away from zero on the magnitude, then saturate to 16 bits signed.
    function automatic logic [IN_W-1:0] round_sat(input logic [ACC_W-1:0] mag,
                                                  input logic [SH_W-1:0]  sh,
                                                  input logic             neg);
        logic [ACC_W-1:0] q;
        q = (mag + (64'd1 << (sh - 6'd1))) >> sh;
        if (neg) begin
            if (q > 64'd32768) begin
                q = 64'd32768;
            end
            round_sat = 16'(64'd0 - q);
        end else begin
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            round_sat = q[IN_W-1:0];
        end
    endfunction

endpackage

// ----- sv/complex_product_rms_normalize.sv -----
// Top level: complex product, RMS scale computation and scaled emission.
//
// Usage: an input transaction (one complex value and one addressed operand) is
// accepted at a rising edge where start is high and busy is low. The block forms
// the complex product (each part wrapped to 32 bits), stores it, and adds its
// squared magnitude, shifted right by 6, to a row sum; busy stays high until the
// pair is through, so no new pair is taken before then. After pairs_in_use pairs
// (0 counts as 1, values above MAX_PAIRS as MAX_PAIRS) the row closes: the sum
// is normalized two bits per cycle, a bit-pair square root is taken, a restoring
// divider forms its reciprocal, a second square root gives sqrt(2n), and the
// MANT and MANT2 states form the scale. A zero sum skips all of that and the row
// emits zeros. Each stored product is then emitted as one result transaction on
// out_re/out_im, marked by out_valid for exactly one cycle, with row_end on the
// last. The receiver cannot stall, so every result is taken when shown.
// All multiplications share one 33x33 multiplier with a registered product.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) is always ready and
// must only be written while the block is idle. Reset (rst_n low) clears the row
// sum, pair count and sequencer and sets pairs_in_use to 64; stored products are
// not cleared since only entries written in the current row are read.
module complex_product_rms_normalize
    import cprn_pkg::*;
#(
    parameter int MAX_PAIRS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [IN_W-1:0]   value_re,
    input  logic signed [IN_W-1:0]   value_im,
    input  logic signed [IN_W-1:0]   addressed_re,
    input  logic signed [IN_W-1:0]   addressed_im,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_data,
    output logic                     out_valid,
    output logic signed [IN_W-1:0]   out_re,
    output logic signed [IN_W-1:0]   out_im,
    output logic                     row_end
);

    localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam logic [CFG_W-1:0] MAX_CNT = CFG_W'(MAX_PAIRS);

    cprn_state_t state_reg, state_next;

    logic [2*Z_W-1:0] store_mem [MAX_PAIRS];

    logic signed [IN_W-1:0] vr_reg, vi_reg, rr_reg, ri_reg;
    logic signed [Z_W-1:0]  zr_reg, zi_reg;
    logic [ACC_W-1:0]       prod_reg, sq_reg, sum_reg;
    logic [CFG_W-1:0]       cfg_reg, count_reg, row_n_reg, emit_k_reg;
    logic                   zero_reg, pass_reg;
    logic [SH_W-1:0]        sh_reg;
    logic [ACC_W-1:0]       x_reg, r_reg, b_reg;
    logic [Z_W-1:0]         s_reg, q_reg, mant_reg;
    logic [Z_W:0]           rem_reg;
    logic [5:0]             div_cnt_reg;
    logic [2*Z_W-1:0]       rd_reg;
    logic [IN_W-1:0]        re_tmp_reg, out_re_reg, out_im_reg;
    logic                   out_valid_reg, row_end_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_full;
    logic [CFG_W-1:0]          target, count_inc;
    logic                      row_done;
    logic [ACC_W-1:0]          new_sum;
    logic [ACC_W-1:0]          rb, x_step, r_step;
    logic [Z_W:0]              rem_sh;
    logic                      rem_ge;
    logic signed [MUL_W-1:0]   zr_ext, zi_ext, zr_abs, zi_abs;
    logic                      emit_last;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign row_end   = row_end_reg;

    // Effective row length with out-of-range register values clamped.
    always_comb
    begin
        if (cfg_reg == '0) begin
            target = CFG_W'(1);
        end else if (cfg_reg > MAX_CNT) begin
            target = MAX_CNT;
        end else begin
            target = cfg_reg;
        end
    end

    assign count_inc = count_reg + CFG_W'(1);
    assign row_done  = (count_inc >= target);
    assign new_sum   = sum_reg + (sq_reg >> 6);

    // One bit pair of the square root.
    assign rb     = r_reg + b_reg;
    assign x_step = (x_reg >= rb) ? (x_reg - rb) : x_reg;
    assign r_step = (x_reg >= rb) ? ((r_reg >> 1) + b_reg) : (r_reg >> 1);

    // One bit of the restoring divider; only bit 61 of the dividend is set.
    assign rem_sh = {rem_reg[Z_W-1:0], (div_cnt_reg == DIV_TOP)};
    assign rem_ge = (rem_sh >= {1'b0, s_reg});

    assign zr_ext = {rd_reg[Z_W-1], rd_reg[Z_W-1:0]};
    assign zi_ext = {rd_reg[2*Z_W-1], rd_reg[2*Z_W-1:Z_W]};
    assign zr_abs = rd_reg[Z_W-1]   ? -zr_ext : zr_ext;
    assign zi_abs = rd_reg[2*Z_W-1] ? -zi_ext : zi_ext;

    assign emit_last = ((emit_k_reg + CFG_W'(1)) == row_n_reg);

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_M_RR:
            begin
                mul_a = MUL_W'(vr_reg);
                mul_b = MUL_W'(rr_reg);
            end
            ST_M_II:
            begin
                mul_a = MUL_W'(vi_reg);
                mul_b = MUL_W'(ri_reg);
            end
            ST_M_RI:
            begin
                mul_a = MUL_W'(vr_reg);
                mul_b = MUL_W'(ri_reg);
            end
            ST_M_IR:
            begin
                mul_a = MUL_W'(vi_reg);
                mul_b = MUL_W'(rr_reg);
            end
            ST_SQ_R:
            begin
                mul_a = MUL_W'(zr_reg);
                mul_b = MUL_W'(zr_reg);
            end
            ST_SQ_I:
            begin
                mul_a = MUL_W'(zi_reg);
                mul_b = MUL_W'(zi_reg);
            end
            ST_MANT:
            begin
                mul_a = {1'b0, r_reg[Z_W-1:0]};
                mul_b = {1'b0, q_reg};
            end
            ST_EMIT_MR:
            begin
                mul_a = zr_abs;
                mul_b = {1'b0, mant_reg};
            end
            ST_EMIT_MI:
            begin
                mul_a = zi_abs;
                mul_b = {1'b0, mant_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (start) state_next = ST_M_RR;
            ST_M_RR:     state_next = ST_M_II;
            ST_M_II:     state_next = ST_M_RI;
            ST_M_RI:     state_next = ST_M_IR;
            ST_M_IR:     state_next = ST_SQ_R;
            ST_SQ_R:     state_next = ST_SQ_I;
            ST_SQ_I:     state_next = ST_SUM;
            ST_SUM:      state_next = ST_ACC;
            ST_ACC:
            begin
                if (!row_done) begin
                    state_next = ST_IDLE;
                end else if (new_sum == '0) begin
                    state_next = ST_EMIT_RD;
                end else begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (x_reg[63:62] == 2'b00 && x_reg[61:60] != 2'b00) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (b_reg[0]) begin
                    state_next = pass_reg ? ST_MANT : ST_DIV;
                end
            end
            ST_DIV:      if (div_cnt_reg == '0) state_next = ST_SQRT;
            ST_MANT:     state_next = ST_MANT2;
            ST_MANT2:    state_next = ST_EMIT_RD;
            ST_EMIT_RD:  state_next = ST_EMIT_MR;
            ST_EMIT_MR:  state_next = ST_EMIT_MI;
            ST_EMIT_MI:  state_next = ST_EMIT_OUT;
            ST_EMIT_OUT: state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= MAX_CNT;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            row_end_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b0;
            row_end_reg   <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_data;
            end
            if (state_reg == ST_ACC) begin
                if (row_done) begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end else begin
                    sum_reg   <= new_sum;
                    count_reg <= count_inc;
                end
            end
            if (state_reg == ST_EMIT_OUT) begin
                out_valid_reg <= 1'b1;
                row_end_reg   <= emit_last;
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[ACC_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                vr_reg <= value_re;
                vi_reg <= value_im;
                rr_reg <= addressed_re;
                ri_reg <= addressed_im;
            end
            ST_M_II:  zr_reg <= signed'(prod_reg[Z_W-1:0]);
            ST_M_RI:  zr_reg <= zr_reg - signed'(prod_reg[Z_W-1:0]);
            ST_M_IR:  zi_reg <= signed'(prod_reg[Z_W-1:0]);
            ST_SQ_R:  zi_reg <= zi_reg + signed'(prod_reg[Z_W-1:0]);
            ST_SQ_I:
            begin
                sq_reg <= prod_reg;
                store_mem[count_reg[IDX_W-1:0]] <= {zi_reg, zr_reg};
            end
            ST_SUM:   sq_reg <= sq_reg + prod_reg;
            ST_ACC:
            begin
                x_reg      <= new_sum;
                sh_reg     <= SH_BASE;
                row_n_reg  <= count_inc;
                emit_k_reg <= '0;
                zero_reg   <= (new_sum == '0);
            end
            ST_NORM:
            begin
                if (x_reg[63:62] != 2'b00) begin
                    x_reg  <= x_reg >> 2;
                    sh_reg <= sh_reg + SH_W'(1);
                end else if (x_reg[61:60] == 2'b00) begin
                    x_reg  <= x_reg << 2;
                    sh_reg <= sh_reg - SH_W'(1);
                end else begin
                    r_reg    <= '0;
                    b_reg    <= 64'd1 << 62;
                    pass_reg <= 1'b0;
                end
            end
            ST_SQRT:
            begin
                x_reg <= x_step;
                r_reg <= r_step;
                b_reg <= b_reg >> 2;
                if (b_reg[0] && !pass_reg) begin
                    s_reg       <= r_step[Z_W-1:0];
                    rem_reg     <= '0;
                    q_reg       <= '0;
                    div_cnt_reg <= DIV_TOP;
                end
            end
            ST_DIV:
            begin
                rem_reg     <= rem_ge ? (rem_sh - {1'b0, s_reg}) : rem_sh;
                q_reg       <= {q_reg[Z_W-2:0], rem_ge};
                div_cnt_reg <= div_cnt_reg - 6'd1;
                if (div_cnt_reg == '0) begin
                    x_reg    <= ACC_W'(row_n_reg) << 55;
                    r_reg    <= '0;
                    b_reg    <= 64'd1 << 62;
                    pass_reg <= 1'b1;
                end
            end
            ST_MANT2:   mant_reg <= prod_reg[62:31];
            ST_EMIT_RD: rd_reg <= store_mem[emit_k_reg[IDX_W-1:0]];
            ST_EMIT_MI:
            begin
                re_tmp_reg <= zero_reg ? '0 : round_sat(prod_reg, sh_reg, rd_reg[Z_W-1]);
            end
            ST_EMIT_OUT:
            begin
                out_re_reg <= re_tmp_reg;
                out_im_reg <= zero_reg ? '0 : round_sat(prod_reg, sh_reg, rd_reg[2*Z_W-1]);
                emit_k_reg <= emit_k_reg + CFG_W'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- sv/cprn_checker.sv -----
// Port-level checker for the complex product RMS normalizer, bound to the top level.
module cprn_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic out_valid,
    input logic row_end
);

    // An accepted transaction always occupies the sequencer.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    // The row end flag is only ever shown with a result.
    a_row_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
        row_end |-> out_valid)
        else $error("row_end without out_valid");

    // Results inside a row are spaced apart, never back to back.
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !row_end) |=> !out_valid)
        else $error("results of one row shown in adjacent cycles");

    // More results of the row are pending, so the block stays busy.
    a_mid_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !row_end) |-> busy)
        else $error("block idle in the middle of a row");

endmodule

bind complex_product_rms_normalize cprn_checker u_cprn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .row_end   (row_end)
);

// ----- tb/sv/complex_product_rms_normalize_tb.sv -----
// Self-checking testbench for the complex product RMS normalizer.
module complex_product_rms_normalize_tb;
    import cprn_pkg::*;

    localparam int MAX_PAIRS   = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 400;
    localparam int RANDOM_ITEMS = 500;

    // One scaled output pair as the block presents it.
    typedef struct {
        logic signed [IN_W-1:0] re;
        logic signed [IN_W-1:0] im;
        logic                   last;
    } scaled_pair_t;

    // One row of the directed table. A row with a literal carries the output
    // that can be read off by hand; it only applies to rows that close there.
    typedef struct {
        logic [CFG_W-1:0]       pairs;
        logic signed [IN_W-1:0] vr;
        logic signed [IN_W-1:0] vi;
        logic signed [IN_W-1:0] ar;
        logic signed [IN_W-1:0] ai;
        bit                     has_lit;
        logic signed [IN_W-1:0] lit_re;
        logic signed [IN_W-1:0] lit_im;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic signed [IN_W-1:0] value_re = '0;
    logic signed [IN_W-1:0] value_im = '0;
    logic signed [IN_W-1:0] addressed_re = '0;
    logic signed [IN_W-1:0] addressed_im = '0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   out_valid;
    logic signed [IN_W-1:0] out_re;
    logic signed [IN_W-1:0] out_im;
    logic                   row_end;

    // Predictor state: stored products, row energy, pair count and register.
    logic signed [Z_W-1:0]  zr_store [MAX_PAIRS];
    logic signed [Z_W-1:0]  zi_store [MAX_PAIRS];
    longint unsigned        row_energy;
    int                     row_fill;
    logic [CFG_W-1:0]       pairs_reg;

    scaled_pair_t           pending_pairs [$];
    int                     fail_count = 0;
    int                     cycle_count = 0;
    int                     sent_items;
    directed_row_t          directed [$];

    complex_product_rms_normalize #(.MAX_PAIRS(MAX_PAIRS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value_re     (value_re),
        .value_im     (value_im),
        .addressed_re (addressed_re),
        .addressed_im (addressed_im),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_re       (out_re),
        .out_im       (out_im),
        .row_end      (row_end)
    );

    always #1 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("complex_product_rms_normalize regression: fail");
            $finish;
        end
    end

    // Floor square root by the bit-pair method.
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale one product component, round half away from zero and saturate.
    // The 64-bit products wrap exactly as the block's datapath does.
    function automatic logic signed [IN_W-1:0] scale_component(
        input logic signed [Z_W-1:0] z, input longint unsigned mant, input int sh);
        longint unsigned mag;
        longint unsigned q;
        longint signed   zl;
        zl = z;
        mag = longint'(zl < 0 ? -zl : zl) * mant;
        q = (mag + (64'd1 << (sh - 1))) >> sh;
        if (zl < 0) begin
            if (q > 32768) q = 32768;
            return IN_W'(-longint'(q));
        end
        if (q > 32767) q = 32767;
        return IN_W'(q);
    endfunction

    // Take one accepted pair into the row; when the row closes, queue every
    // scaled output that it produces.
    task automatic absorb_pair(input logic signed [IN_W-1:0] vr,
                               input logic signed [IN_W-1:0] vi,
                               input logic signed [IN_W-1:0] ar,
                               input logic signed [IN_W-1:0] ai);
        longint signed   zr;
        longint signed   zi;
        int              goal;
        int              shift_up;
        longint unsigned a;
        longint unsigned s;
        longint unsigned rcp;
        longint unsigned g;
        longint unsigned mant;
        scaled_pair_t    sp;
        zr = longint'(vr) * longint'(ar) - longint'(vi) * longint'(ai);
        zi = longint'(vr) * longint'(ai) + longint'(vi) * longint'(ar);
        goal = int'(pairs_reg);
        if (goal < 1) goal = 1;
        if (goal > MAX_PAIRS) goal = MAX_PAIRS;
        // The store keeps 32 bits; the energy uses the exact product.
        zr_store[row_fill] = zr[Z_W-1:0];
        zi_store[row_fill] = zi[Z_W-1:0];
        row_energy = row_energy + (longint'(zr * zr + zi * zi) >> 6);
        row_fill = row_fill + 1;
        if (row_fill < goal) return;
        if (row_energy == 0) begin
            for (int k = 0; k < row_fill; k++) begin
                sp.re = '0;
                sp.im = '0;
                sp.last = (k + 1 == row_fill);
                pending_pairs = {pending_pairs, sp};
            end
        end else begin
            a = row_energy;
            shift_up = 0;
            while (a >= (64'd1 << 62)) begin
                a = a >> 2;
                shift_up = shift_up - 1;
            end
            while (a < (64'd1 << 60)) begin
                a = a << 2;
                shift_up = shift_up + 1;
            end
            s = floor_sqrt(a);
            rcp = (64'd1 << 61) / s;
            g = floor_sqrt(longint'(2 * row_fill) << 54);
            mant = (g * rcp) >> 31;
            for (int k = 0; k < row_fill; k++) begin
                sp.re = scale_component(zr_store[k], mant, 50 - shift_up);
                sp.im = scale_component(zi_store[k], mant, 50 - shift_up);
                sp.last = (k + 1 == row_fill);
                pending_pairs = {pending_pairs, sp};
            end
        end
        row_energy = 0;
        row_fill = 0;
    endtask

    // Mostly short gaps, now and then a long one, often none at all.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Present one input transaction and hold it until the block takes it.
    // Start is only lowered when a gap follows, so back-to-back items keep it
    // high without a second assignment in the same step.
    task automatic send_pair(input logic signed [IN_W-1:0] vr,
                             input logic signed [IN_W-1:0] vi,
                             input logic signed [IN_W-1:0] ar,
                             input logic signed [IN_W-1:0] ai);
        int gap;
        start <= 1'b1;
        value_re <= vr;
        value_im <= vi;
        addressed_re <= ar;
        addressed_im <= ai;
        do @(posedge clk); while (busy);
        absorb_pair(vr, vi, ar, ai);
        sent_items = sent_items + 1;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let the block drain before touching the register. A pair that closes no
    // row still leaves the block busy while it is summed, with no result to wait for.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_pairs(input logic [CFG_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        pairs_reg = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [IN_W-1:0] rand_field(input int mode);
        case (mode)
            0: return IN_W'($urandom);
            1: return IN_W'($urandom_range(0, 255)) - 16'sd128;
            2: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            default: return '0;
        endcase
    endfunction

    // Result side: every strobe is a transaction that must match the oldest
    // queued expectation.
    always @(posedge clk)
    begin
        scaled_pair_t want;
        if (rst_n && out_valid) begin
            if (pending_pairs.size() == 0) begin
                $display("%0t: unexpected result re=%0d im=%0d last=%0b",
                         $time, out_re, out_im, row_end);
                fail_count = fail_count + 1;
            end else begin
                want = pending_pairs.pop_front();
                if (out_re !== want.re || out_im !== want.im || row_end !== want.last) begin
                    $display("%0t: mismatch expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                             $time, want.re, want.im, want.last, out_re, out_im, row_end);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    function automatic directed_row_t drow(input logic [CFG_W-1:0] p,
        input logic signed [IN_W-1:0] vr, input logic signed [IN_W-1:0] vi,
        input logic signed [IN_W-1:0] ar, input logic signed [IN_W-1:0] ai,
        input bit lit, input logic signed [IN_W-1:0] lre, input logic signed [IN_W-1:0] lim);
        directed_row_t r;
        r.pairs = p;
        r.vr = vr;
        r.vi = vi;
        r.ar = ar;
        r.ai = ai;
        r.has_lit = lit;
        r.lit_re = lre;
        r.lit_im = lim;
        return r;
    endfunction

    initial
    begin
        int           pairs_now;
        int           rows;
        int           mode;
        int           goal;
        int           partial;
        int           before_len;
        scaled_pair_t got;

        row_energy = 0;
        row_fill = 0;
        pairs_reg = 7'd64;
        sent_items = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Single-pair rows first: zero inputs give zero output,
        // the extremes saturate or wrap the 32-bit product.
        directed = {directed, drow(7'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                   1'b1, 16'sd0, 16'sd0)};
        directed = {directed, drow(7'd1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                                   1'b0, 16'sd0, 16'sd0)};
        directed = {directed, drow(7'd1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                   1'b0, 16'sd0, 16'sd0)};
        directed = {directed, drow(7'd1, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                                   1'b0, 16'sd0, 16'sd0)};
        directed = {directed, drow(7'd1, 16'sd1, 16'sd0, 16'sd1, 16'sd0,
                                   1'b0, 16'sd0, 16'sd0)};
        directed = {directed, drow(7'd1, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
                                   1'b0, 16'sd0, 16'sd0)};
        // A register of zero behaves as one pair per row.
        directed = {directed, drow(7'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                   1'b1, 16'sd0, 16'sd0)};
        directed = {directed, drow(7'd0, -16'sd5, 16'sd3, 16'sd7, -16'sd2,
                                   1'b0, 16'sd0, 16'sd0)};
        // Three-pair rows: an all-zero row, then a row with one tiny product
        // among large ones.
        directed = {directed, drow(7'd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                   1'b0, 16'sd0, 16'sd0)};
        directed = {directed, drow(7'd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                   1'b0, 16'sd0, 16'sd0)};
        directed = {directed, drow(7'd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                   1'b1, 16'sd0, 16'sd0)};
        directed = {directed, drow(7'd3, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
                                   1'b0, 16'sd0, 16'sd0)};
        directed = {directed, drow(7'd3, 16'sd1, 16'sd1, 16'sd1, -16'sd1,
                                   1'b0, 16'sd0, 16'sd0)};
        directed = {directed, drow(7'd3, -16'sd20000, 16'sd12345, 16'sd300, -16'sd9999,
                                   1'b0, 16'sd0, 16'sd0)};

        foreach (directed[i]) begin
            if (directed[i].pairs != pairs_reg) write_pairs(directed[i].pairs);
            before_len = pending_pairs.size();
            send_pair(directed[i].vr, directed[i].vi, directed[i].ar, directed[i].ai);
            if (directed[i].has_lit && pending_pairs.size() > before_len) begin
                got = pending_pairs[pending_pairs.size() - 1];
                if (got.re !== directed[i].lit_re || got.im !== directed[i].lit_im) begin
                    $display("%0t: table row %0d expected re=%0d im=%0d, predicted re=%0d im=%0d",
                             $time, i, directed[i].lit_re, directed[i].lit_im, got.re, got.im);
                    fail_count = fail_count + 1;
                end
            end
        end

        // Lowering the register mid-row: three pairs wait in a row of eight,
        // then a setting of two makes the next pair close the row with four.
        write_pairs(7'd8);
        repeat (3) send_pair(rand_field(0), rand_field(0), rand_field(0), rand_field(0));
        write_pairs(7'd2);
        send_pair(rand_field(0), rand_field(0), rand_field(0), rand_field(0));

        // One full row at the largest setting, then one above the maximum.
        write_pairs(7'd64);
        repeat (64) send_pair(rand_field(0), rand_field(0), rand_field(0), rand_field(0));
        write_pairs(7'd127);
        repeat (64) send_pair(rand_field(1), rand_field(1), rand_field(1), rand_field(1));

        // Random phases: mostly short rows with random content, now and then a
        // register extreme, an all-zero row or a row cut short by a lower setting.
        while (sent_items < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 99);
            if (mode < 70) pairs_now = $urandom_range(1, 8);
            else if (mode < 80) pairs_now = $urandom_range(9, 64);
            else if (mode < 88) pairs_now = 0;
            else pairs_now = $urandom_range(65, 127);
            if (pairs_now > 16 && $urandom_range(0, 3) != 0) pairs_now = $urandom_range(1, 4);
            write_pairs(CFG_W'(pairs_now));
            goal = (pairs_now < 1) ? 1 : (pairs_now > MAX_PAIRS ? MAX_PAIRS : pairs_now);
            rows = $urandom_range(1, goal > 8 ? 1 : 4);
            mode = $urandom_range(0, 9);
            repeat (rows * goal) begin
                if (mode == 0)
                    send_pair('0, '0, '0, '0);
                else
                    send_pair(rand_field($urandom_range(0, 2)), rand_field($urandom_range(0, 2)),
                              rand_field($urandom_range(0, 2)), rand_field($urandom_range(0, 2)));
            end
            // Leave a partial row behind and close it with a lower setting.
            if (goal > 2 && $urandom_range(0, 4) == 0) begin
                partial = $urandom_range(1, goal - 1);
                repeat (partial) send_pair(rand_field(0), rand_field(0), rand_field(0), rand_field(0));
                write_pairs(CFG_W'($urandom_range(0, partial)));
                send_pair(rand_field(0), rand_field(0), rand_field(0), rand_field(0));
            end
        end

        // Drain and allow the tail latency before judging the run.
        start <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending_pairs.size() == 0) begin
            $display("complex_product_rms_normalize regression: pass");
        end else begin
            $display("complex_product_rms_normalize regression: fail");
        end
        $finish;
    end

endmodule
